>>> src/cawf_pkg.sv
// ----------------------------------------------------------------------------
// cawf_pkg
// Shared types and codes for the 16-bit ALU with x86-style flags.
// ----------------------------------------------------------------------------
package cawf_pkg;

  // Operation codes (opcode field)
  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_OR    = 4'd1;
  localparam logic [3:0] OP_ADC   = 4'd2;
  localparam logic [3:0] OP_SBB   = 4'd3;
  localparam logic [3:0] OP_AND   = 4'd4;
  localparam logic [3:0] OP_SUB   = 4'd5;
  localparam logic [3:0] OP_XOR   = 4'd6;
  localparam logic [3:0] OP_CMP   = 4'd7;
  localparam logic [3:0] OP_INC   = 4'd8;
  localparam logic [3:0] OP_DEC   = 4'd9;
  localparam logic [3:0] OP_INC2  = 4'd10;
  localparam logic [3:0] OP_DEC2  = 4'd11;
  localparam logic [3:0] OP_NOT   = 4'd12;
  localparam logic [3:0] OP_NEG   = 4'd13;
  localparam logic [3:0] OP_PASS  = 4'd14;
  localparam logic [3:0] OP_INSTR = 4'd15;

  // Port B source codes
  localparam logic [1:0] PB_TEMP_A = 2'd0;
  localparam logic [1:0] PB_TEMP_B = 2'd1;
  localparam logic [1:0] PB_TEMP_C = 2'd2;
  localparam logic [1:0] PB_ZERO   = 2'd3;

  // Flag bit positions (x86 layout)
  localparam int unsigned F_CY_BIT = 0;
  localparam int unsigned F_P_BIT  = 2;
  localparam int unsigned F_AC_BIT = 4;
  localparam int unsigned F_Z_BIT  = 6;
  localparam int unsigned F_S_BIT  = 7;
  localparam int unsigned F_V_BIT  = 11;

  localparam logic [15:0] F_ALL  = 16'h08D5;
  localparam logic [15:0] F_NOCY = 16'h08D4;

  typedef enum logic [1:0] {
    X_PORT_A,
    X_PORT_B,
    X_ZERO
  } x_sel_e;

  typedef enum logic [1:0] {
    Y_PORT_B,
    Y_ONE,
    Y_TWO
  } y_sel_e;

  typedef enum logic [2:0] {
    RES_ADDER,
    RES_OR,
    RES_AND,
    RES_XOR,
    RES_NOT,
    RES_PASS,
    RES_CONST
  } res_sel_e;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [7:0]  instruction_byte;
    logic        inc_dec_group;
    logic        byte_width;
    logic [15:0] temp_a;
    logic [15:0] temp_b;
    logic [15:0] temp_c;
    logic [1:0]  port_b_select;
    logic        carry_in;
    logic        constant_mode;
    logic [15:0] constant_value;
  } alu_in_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic [15:0] flag_values;
    logic [15:0] flag_write_mask;
    logic        commit_result;
  } alu_out_t;

  // Decoded controls from the decoder to the datapath
  typedef struct packed {
    x_sel_e   x_sel;
    y_sel_e   y_sel;
    res_sel_e res_sel;
    logic     sub;
    logic     use_cin;
    logic     is_arith;
    logic     byte_mode;
    logic     flags_write;
    logic     cy_write;
    logic     commit;
  } alu_ctrl_t;

endpackage

>>> src/cpu_alu_with_flags.sv
// ----------------------------------------------------------------------------
// cpu_alu_with_flags
// 16-bit ALU with x86-style flag generation, registered in and out.
// ----------------------------------------------------------------------------
// A transaction is taken on every clock edge where start_i is high; busy_o is
// always low, so a new operation can be issued every cycle. The operands are
// captured in an input register, decoded and computed in one combinational
// pass, and captured in the result register; each result is driven on
// result_o from the result register, marked by done_o for one cycle, in
// issue order. The receiver cannot stall, so it must take every result in
// the cycle done_o is high. The result value is always the full 16-bit
// operation; flags use 8- or 16-bit operands per byte_width. flag_write_mask
// tells which flag bits (CY 0, P 2, AC 4, Z 6, S 7, V 11) the caller should
// update, and commit_result is low for compare.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  cawf_pkg::alu_in_t  in_i,
  output logic               done_o,
  output cawf_pkg::alu_out_t result_o
);

  cawf_pkg::alu_in_t   in_q;
  logic                vld_q;
  cawf_pkg::alu_ctrl_t ctrl;
  cawf_pkg::alu_out_t  res_d, res_q;
  logic                done_q;

  // never stalls: one transaction per cycle
  assign busy_o = 1'b0;

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q <= in_i;
    end
  end

  cawf_decode u_decode (
    .op_i   (in_q),
    .ctrl_o (ctrl)
  );

  cawf_datapath u_datapath (
    .op_i   (in_q),
    .ctrl_i (ctrl),
    .res_o  (res_d)
  );

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // A taken transaction yields a done_o strobe through the input and result registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("result missing two cycles after transaction");

  // Flag bits outside the write mask are always zero.
  a_flags_in_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((result_o.flag_values & ~result_o.flag_write_mask) == 16'h0000))
    else $error("flag value set outside write mask");

  // A non-committing result is a compare, which writes all flags.
  a_cmp_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.commit_result) |-> (result_o.flag_write_mask == cawf_pkg::F_ALL))
    else $error("compare without full flag mask");

  // Constant mode passes the value with no flag update.
  a_const: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && in_q.constant_mode) |=>
      (result_o.flag_write_mask == 16'h0000 && result_o.commit_result &&
       result_o.result_value == $past(in_q.constant_value)))
    else $error("constant mode result mismatch");

endmodule

>>> src/cawf_decode.sv
// ----------------------------------------------------------------------------
// cawf_decode
// Resolves the operation (incl. instruction-byte mode) into datapath controls.
// ----------------------------------------------------------------------------
module cawf_decode (
  input  cawf_pkg::alu_in_t   op_i,
  output cawf_pkg::alu_ctrl_t ctrl_o
);

  logic [3:0] op;

  always_comb begin
    op = op_i.opcode;
    if (op_i.opcode == cawf_pkg::OP_INSTR) begin
      if (op_i.inc_dec_group) begin
        op = op_i.instruction_byte[3] ? cawf_pkg::OP_DEC : cawf_pkg::OP_INC;
      end else begin
        op = {1'b0, op_i.instruction_byte[5:3]};
      end
    end
  end

  always_comb begin
    ctrl_o             = '0;
    ctrl_o.x_sel       = cawf_pkg::X_PORT_A;
    ctrl_o.y_sel       = cawf_pkg::Y_PORT_B;
    ctrl_o.res_sel     = cawf_pkg::RES_PASS;
    ctrl_o.byte_mode   = op_i.byte_width;
    ctrl_o.commit      = 1'b1;
    ctrl_o.flags_write = 1'b1;
    ctrl_o.cy_write    = 1'b1;
    case (op)
      cawf_pkg::OP_ADD, cawf_pkg::OP_ADC: begin
        ctrl_o.res_sel  = cawf_pkg::RES_ADDER;
        ctrl_o.is_arith = 1'b1;
        ctrl_o.use_cin  = (op == cawf_pkg::OP_ADC);
      end
      cawf_pkg::OP_SUB, cawf_pkg::OP_SBB, cawf_pkg::OP_CMP: begin
        ctrl_o.res_sel  = cawf_pkg::RES_ADDER;
        ctrl_o.is_arith = 1'b1;
        ctrl_o.sub      = 1'b1;
        ctrl_o.use_cin  = (op == cawf_pkg::OP_SBB);
        ctrl_o.commit   = (op != cawf_pkg::OP_CMP);
      end
      cawf_pkg::OP_OR:  ctrl_o.res_sel = cawf_pkg::RES_OR;
      cawf_pkg::OP_AND: ctrl_o.res_sel = cawf_pkg::RES_AND;
      cawf_pkg::OP_XOR: ctrl_o.res_sel = cawf_pkg::RES_XOR;
      cawf_pkg::OP_INC, cawf_pkg::OP_DEC: begin
        ctrl_o.res_sel  = cawf_pkg::RES_ADDER;
        ctrl_o.is_arith = 1'b1;
        ctrl_o.x_sel    = cawf_pkg::X_PORT_B;
        ctrl_o.y_sel    = cawf_pkg::Y_ONE;
        ctrl_o.sub      = (op == cawf_pkg::OP_DEC);
        ctrl_o.cy_write = 1'b0;
      end
      cawf_pkg::OP_INC2, cawf_pkg::OP_DEC2: begin
        ctrl_o.res_sel     = cawf_pkg::RES_ADDER;
        ctrl_o.x_sel       = cawf_pkg::X_PORT_B;
        ctrl_o.y_sel       = cawf_pkg::Y_TWO;
        ctrl_o.sub         = (op == cawf_pkg::OP_DEC2);
        ctrl_o.byte_mode   = 1'b0;
        ctrl_o.flags_write = 1'b0;
      end
      cawf_pkg::OP_NOT: begin
        ctrl_o.res_sel     = cawf_pkg::RES_NOT;
        ctrl_o.flags_write = 1'b0;
      end
      cawf_pkg::OP_NEG: begin
        // 0 - b: borrow equals "result nonzero", V equals "operand is sign bit"
        ctrl_o.res_sel  = cawf_pkg::RES_ADDER;
        ctrl_o.is_arith = 1'b1;
        ctrl_o.x_sel    = cawf_pkg::X_ZERO;
        ctrl_o.sub      = 1'b1;
      end
      default: begin
        ctrl_o.res_sel     = cawf_pkg::RES_PASS;
        ctrl_o.flags_write = 1'b0;
      end
    endcase
    if (op_i.constant_mode) begin
      ctrl_o.res_sel     = cawf_pkg::RES_CONST;
      ctrl_o.flags_write = 1'b0;
      ctrl_o.commit      = 1'b1;
    end
  end

endmodule

>>> src/cawf_datapath.sv
// ----------------------------------------------------------------------------
// cawf_datapath
// Operand select, adder, logic unit, result mux and flag generation.
// ----------------------------------------------------------------------------
module cawf_datapath (
  input  cawf_pkg::alu_in_t   op_i,
  input  cawf_pkg::alu_ctrl_t ctrl_i,
  output cawf_pkg::alu_out_t  res_o
);

  logic [15:0] port_a, port_b, x_full, y_full, y_eff, sum_full, logic_res, flag_src;
  logic [15:0] x_m, y_m, flags;
  logic [16:0] y17, sum17;
  logic        c_in, c_eff, bw;
  logic        cy, ac, zf, sf, pf, vf, xs, ys;

  assign port_a = op_i.temp_b;
  assign bw     = ctrl_i.byte_mode;

  always_comb begin
    case (op_i.port_b_select)
      cawf_pkg::PB_TEMP_A: port_b = op_i.temp_a;
      cawf_pkg::PB_TEMP_B: port_b = op_i.temp_b;
      cawf_pkg::PB_TEMP_C: port_b = op_i.temp_c;
      default:             port_b = 16'h0000;
    endcase
  end

  always_comb begin
    case (ctrl_i.x_sel)
      cawf_pkg::X_PORT_A: x_full = port_a;
      cawf_pkg::X_PORT_B: x_full = port_b;
      default:            x_full = 16'h0000;
    endcase
    case (ctrl_i.y_sel)
      cawf_pkg::Y_ONE: y_full = 16'h0001;
      cawf_pkg::Y_TWO: y_full = 16'h0002;
      default:         y_full = port_b;
    endcase
  end

  // subtract as x + ~y + ~borrow
  assign c_in     = ctrl_i.use_cin & op_i.carry_in;
  assign c_eff    = ctrl_i.sub ? ~c_in : c_in;
  assign y_eff    = ctrl_i.sub ? ~y_full : y_full;
  assign sum_full = x_full + y_eff + {15'b0, c_eff};

  // flag adder on operands masked to the flag width
  assign x_m   = bw ? {8'h00, x_full[7:0]} : x_full;
  assign y_m   = bw ? {8'h00, y_full[7:0]} : y_full;
  assign y17   = ctrl_i.sub ? ~{1'b0, y_m} : {1'b0, y_m};
  assign sum17 = {1'b0, x_m} + y17 + {16'b0, c_eff};

  always_comb begin
    case (ctrl_i.res_sel)
      cawf_pkg::RES_OR:  logic_res = port_a | port_b;
      cawf_pkg::RES_AND: logic_res = port_a & port_b;
      cawf_pkg::RES_XOR: logic_res = port_a ^ port_b;
      cawf_pkg::RES_NOT: logic_res = ~port_b;
      default:           logic_res = port_b;
    endcase
  end

  assign flag_src = ctrl_i.is_arith ? sum17[15:0] : logic_res;
  assign zf = bw ? (flag_src[7:0] == 8'h00) : (flag_src == 16'h0000);
  assign sf = bw ? flag_src[7] : flag_src[15];
  assign pf = ~^flag_src[7:0];
  assign xs = bw ? x_m[7] : x_m[15];
  assign ys = bw ? y_m[7] : y_m[15];
  assign cy = ctrl_i.is_arith & ctrl_i.cy_write & (bw ? sum17[8] : sum17[16]);
  assign ac = ctrl_i.is_arith & (x_m[4] ^ y_m[4] ^ sum17[4]);
  assign vf = ctrl_i.is_arith & (ctrl_i.sub ? ((xs ^ ys) & (xs ^ sf))
                                            : (~(xs ^ ys) & (xs ^ sf)));

  always_comb begin
    flags                     = 16'h0000;
    flags[cawf_pkg::F_CY_BIT] = cy;
    flags[cawf_pkg::F_P_BIT]  = pf;
    flags[cawf_pkg::F_AC_BIT] = ac;
    flags[cawf_pkg::F_Z_BIT]  = zf;
    flags[cawf_pkg::F_S_BIT]  = sf;
    flags[cawf_pkg::F_V_BIT]  = vf;
  end

  always_comb begin
    case (ctrl_i.res_sel)
      cawf_pkg::RES_ADDER: res_o.result_value = sum_full;
      cawf_pkg::RES_CONST: res_o.result_value = op_i.constant_value;
      default:             res_o.result_value = logic_res;
    endcase
    res_o.flag_values     = ctrl_i.flags_write ? flags : 16'h0000;
    res_o.flag_write_mask = ctrl_i.flags_write ?
                            (ctrl_i.cy_write ? cawf_pkg::F_ALL : cawf_pkg::F_NOCY) :
                            16'h0000;
    res_o.commit_result   = ctrl_i.commit;
  end

endmodule

>>> dv/cpu_alu_with_flags_test.sv
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_test
// Self-checking testbench for the 16-bit ALU with x86-style flags.
// ----------------------------------------------------------------------------
// A queue of operations is built at time zero: a directed set that hits the
// operand extremes, every opcode, the instruction-byte decode and the special
// flag cases, then about 1200 random operations. A clocked driver issues them
// with random gaps, and a golden function computes each expected result when
// the transaction is accepted. A clocked monitor compares every done_o strobe
// against the oldest expected result, field by field.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_RANDOM    = 1200;
  localparam int unsigned MAX_GAP     = 13;
  localparam int unsigned GAP_BLOCK   = 40;    // items per idling regime
  localparam int unsigned DRAIN_CYC   = 8;     // idle time after the last result
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               start_i = 1'b0;
  cawf_pkg::alu_in_t  in_i    = '0;
  logic               busy_o;
  logic               done_o;
  cawf_pkg::alu_out_t result_o;

  cpu_alu_with_flags u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .in_i     (in_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  cawf_pkg::alu_in_t  pending_ops[$];     // operations not yet issued
  int unsigned        issue_gaps[$];      // idle cycles after each operation
  cawf_pkg::alu_out_t awaited_results[$]; // predicted results, issue order

  int unsigned n_issued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked  = 0;
  int unsigned n_errors   = 0;
  int unsigned n_const    = 0;
  int unsigned n_bytew    = 0;
  logic [15:0] ops_seen   = '0;
  int unsigned gap_left   = 0;
  int unsigned cycle_cnt  = 0;

  // --------------------------------------------------------------------------
  // Golden ALU: full 16-bit result, flags on operands masked to 8 or 16 bits.
  // --------------------------------------------------------------------------
  function automatic cawf_pkg::alu_out_t compute_alu_out(cawf_pkg::alu_in_t t);
    cawf_pkg::alu_out_t o;
    logic [3:0]  op;
    logic        bw;
    logic        cin_eff;
    logic        commit;
    logic [15:0] af, bf, wm, full, f, fm;
    logic [31:0] a, b, r, ac_vec, v_vec;
    int          sb;
    o = '0;
    // Constant mode: value passes through, nothing written in the flags
    if (t.constant_mode) begin
      o.result_value  = t.constant_value;
      o.commit_result = 1'b1;
      return o;
    end
    op = t.opcode;
    if (op == cawf_pkg::OP_INSTR) begin
      if (t.inc_dec_group) op = t.instruction_byte[3] ? cawf_pkg::OP_DEC : cawf_pkg::OP_INC;
      else op = {1'b0, t.instruction_byte[5:3]};
    end
    // inc2/dec2 always count as word width
    bw = t.byte_width && (op != cawf_pkg::OP_INC2) && (op != cawf_pkg::OP_DEC2);
    af = t.temp_b;
    case (t.port_b_select)
      cawf_pkg::PB_TEMP_A: bf = t.temp_a;
      cawf_pkg::PB_TEMP_B: bf = t.temp_b;
      cawf_pkg::PB_TEMP_C: bf = t.temp_c;
      default:             bf = '0;
    endcase
    wm = bw ? 16'h00FF : 16'hFFFF;
    sb = bw ? 7 : 15;
    a = {16'h0, af & wm};
    b = {16'h0, bf & wm};
    r = '0;
    f = '0;
    fm = '0;
    commit = 1'b1;
    full = bf;
    case (op)
      cawf_pkg::OP_ADD, cawf_pkg::OP_ADC: begin
        cin_eff = (op == cawf_pkg::OP_ADC) && t.carry_in;
        r = a + b + cin_eff;
        full = af + bf + cin_eff;
        fm = cawf_pkg::F_ALL;
        f[cawf_pkg::F_CY_BIT] = r[sb+1];
        ac_vec = a ^ b ^ r;
        f[cawf_pkg::F_AC_BIT] = ac_vec[4];
        v_vec = ~(a ^ b) & (a ^ r);
        f[cawf_pkg::F_V_BIT] = v_vec[sb];
      end
      cawf_pkg::OP_SBB, cawf_pkg::OP_SUB, cawf_pkg::OP_CMP: begin
        cin_eff = (op == cawf_pkg::OP_SBB) && t.carry_in;
        r = a - b - cin_eff;
        full = af - bf - cin_eff;
        fm = cawf_pkg::F_ALL;
        f[cawf_pkg::F_CY_BIT] = r[sb+1];   // borrow out
        ac_vec = a ^ b ^ r;
        f[cawf_pkg::F_AC_BIT] = ac_vec[4];
        v_vec = (a ^ b) & (a ^ r);
        f[cawf_pkg::F_V_BIT] = v_vec[sb];
        if (op == cawf_pkg::OP_CMP) commit = 1'b0;
      end
      cawf_pkg::OP_OR: begin
        r = a | b;
        full = af | bf;
        fm = cawf_pkg::F_ALL;
      end
      cawf_pkg::OP_AND: begin
        r = a & b;
        full = af & bf;
        fm = cawf_pkg::F_ALL;
      end
      cawf_pkg::OP_XOR: begin
        r = a ^ b;
        full = af ^ bf;
        fm = cawf_pkg::F_ALL;
      end
      cawf_pkg::OP_INC: begin
        r = b + 32'd1;
        full = bf + 16'd1;
        fm = cawf_pkg::F_NOCY;
        ac_vec = b ^ 32'd1 ^ r;
        f[cawf_pkg::F_AC_BIT] = ac_vec[4];
        v_vec = ~(b ^ 32'd1) & (b ^ r);
        f[cawf_pkg::F_V_BIT] = v_vec[sb];
      end
      cawf_pkg::OP_DEC: begin
        r = b - 32'd1;
        full = bf - 16'd1;
        fm = cawf_pkg::F_NOCY;
        ac_vec = b ^ 32'd1 ^ r;
        f[cawf_pkg::F_AC_BIT] = ac_vec[4];
        v_vec = (b ^ 32'd1) & (b ^ r);
        f[cawf_pkg::F_V_BIT] = v_vec[sb];
      end
      cawf_pkg::OP_INC2: full = bf + 16'd2;
      cawf_pkg::OP_DEC2: full = bf - 16'd2;
      cawf_pkg::OP_NOT:  full = ~bf;
      cawf_pkg::OP_NEG: begin
        r = 32'd0 - b;
        full = 16'd0 - bf;
        fm = cawf_pkg::F_ALL;
        f[cawf_pkg::F_CY_BIT] = (r[15:0] & wm) != 16'h0;
        ac_vec = b ^ r;
        f[cawf_pkg::F_AC_BIT] = ac_vec[4];
        f[cawf_pkg::F_V_BIT] = (b[15:0] == (bw ? 16'h0080 : 16'h8000));
      end
      default: full = bf;
    endcase
    // S, Z, P from the masked result for every flag-writing op
    if (fm != '0) begin
      f[cawf_pkg::F_Z_BIT] = (r[15:0] & wm) == 16'h0;
      f[cawf_pkg::F_S_BIT] = r[sb];
      f[cawf_pkg::F_P_BIT] = ~^r[7:0];
    end
    o.result_value    = full;
    o.flag_values     = f;
    o.flag_write_mask = fm;
    o.commit_result   = commit;
    return o;
  endfunction

  // Operand biased toward the carry/sign/overflow corners
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      4:       return 16'h00FF;
      5:       return 16'h0080;
      6:       return 16'h007F;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cawf_pkg::alu_in_t rand_op();
    cawf_pkg::alu_in_t t;
    t.opcode           = 4'($urandom);
    t.instruction_byte = 8'($urandom);
    t.inc_dec_group    = 1'($urandom);
    t.byte_width       = 1'($urandom);
    t.temp_a           = pick_operand();
    t.temp_b           = pick_operand();
    t.temp_c           = pick_operand();
    t.port_b_select    = 2'($urandom);
    t.carry_in         = 1'($urandom);
    t.constant_mode    = ($urandom_range(0, 7) == 0);
    t.constant_value   = pick_operand();
    return t;
  endfunction

  // Directed operation: random filler, then the fields that matter
  function automatic cawf_pkg::alu_in_t make_op(logic [3:0] op, logic bw, logic [15:0] tb,
                                                logic [15:0] other, logic [1:0] sel,
                                                logic cin);
    cawf_pkg::alu_in_t t;
    t = rand_op();
    t.opcode        = op;
    t.byte_width    = bw;
    t.temp_b        = tb;
    t.temp_a        = other;
    t.temp_c        = other;
    t.port_b_select = sel;
    t.carry_in      = cin;
    t.constant_mode = 1'b0;
    return t;
  endfunction

  task automatic queue_op(cawf_pkg::alu_in_t t, int unsigned gap);
    pending_ops.push_back(t);
    issue_gaps.push_back(gap);
    n_issued++;
    if (t.constant_mode) n_const++;
    else begin
      ops_seen[t.opcode] = 1'b1;
      if (t.byte_width) n_bytew++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: one transaction per start_i && !busy_o edge; the golden result is
  // queued at the edge that accepts it.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i  <= 1'b0;
      in_i     <= '0;
      gap_left = 0;
    end else begin
      if (start_i && !busy_o) begin
        awaited_results.push_back(compute_alu_out(in_i));
        n_accepted++;
      end
      // hold the offer while busy; otherwise idle out the gap, then issue
      if (!(start_i && busy_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          in_i     <= pending_ops.pop_front();
          gap_left = issue_gaps.pop_front();
          start_i  <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every done_o strobe must match the oldest expected result.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cawf_pkg::alu_out_t exp_r;
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: value %h flags %h mask %h commit %b",
               result_o.result_value, result_o.flag_values,
               result_o.flag_write_mask, result_o.commit_result);
        n_errors++;
      end else begin
        exp_r = awaited_results.pop_front();
        n_checked++;
        if (result_o.result_value !== exp_r.result_value) begin
          $error("result_value: expected %h, got %h",
                 exp_r.result_value, result_o.result_value);
          n_errors++;
        end
        if (result_o.flag_values !== exp_r.flag_values) begin
          $error("flag_values: expected %h, got %h",
                 exp_r.flag_values, result_o.flag_values);
          n_errors++;
        end
        if (result_o.flag_write_mask !== exp_r.flag_write_mask) begin
          $error("flag_write_mask: expected %h, got %h",
                 exp_r.flag_write_mask, result_o.flag_write_mask);
          n_errors++;
        end
        if (result_o.commit_result !== exp_r.commit_result) begin
          $error("commit_result: expected %b, got %b",
                 exp_r.commit_result, result_o.commit_result);
          n_errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_cnt, awaited_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    cawf_pkg::alu_in_t t;
    int unsigned       gap;
    bit                burst;

    // ---- directed: extremes, every opcode, decode paths, flag corners ----
    t = rand_op();
    t.constant_mode  = 1'b1;              // pass-through, compare opcode
    t.opcode         = cawf_pkg::OP_CMP;
    t.constant_value = 16'hFFFF;
    queue_op(t, 0);
    queue_op(make_op(cawf_pkg::OP_ADD, 1'b0, 16'hFFFF, 16'h0001, cawf_pkg::PB_TEMP_A, 1'b0), 0);
    queue_op(make_op(cawf_pkg::OP_ADD, 1'b1, 16'h127F, 16'h3401, cawf_pkg::PB_TEMP_C, 1'b1), 0);
    queue_op(make_op(cawf_pkg::OP_ADC, 1'b0, 16'hFFFF, 16'hFFFF, cawf_pkg::PB_TEMP_A, 1'b1), 0);
    queue_op(make_op(cawf_pkg::OP_SBB, 1'b1, 16'h0000, 16'h0000, cawf_pkg::PB_ZERO,   1'b1), 0);
    queue_op(make_op(cawf_pkg::OP_SUB, 1'b0, 16'h8000, 16'h0001, cawf_pkg::PB_TEMP_A, 1'b0), 1);
    queue_op(make_op(cawf_pkg::OP_CMP, 1'b0, 16'h1234, 16'h0000, cawf_pkg::PB_TEMP_B, 1'b0), 0);
    queue_op(make_op(cawf_pkg::OP_OR,  1'b0, 16'hAAAA, 16'h5555, cawf_pkg::PB_TEMP_A, 1'b1), 0);
    queue_op(make_op(cawf_pkg::OP_AND, 1'b1, 16'hAAAA, 16'h5555, cawf_pkg::PB_TEMP_C, 1'b1), 0);
    queue_op(make_op(cawf_pkg::OP_XOR, 1'b0, 16'hFFFF, 16'h0000, cawf_pkg::PB_TEMP_B, 1'b0), 2);
    queue_op(make_op(cawf_pkg::OP_INC, 1'b0, 16'h0000, 16'h7FFF, cawf_pkg::PB_TEMP_A, 1'b1), 0);
    queue_op(make_op(cawf_pkg::OP_INC, 1'b1, 16'h0000, 16'h00FF, cawf_pkg::PB_TEMP_C, 1'b1), 0);
    queue_op(make_op(cawf_pkg::OP_DEC, 1'b0, 16'h0000, 16'h8000, cawf_pkg::PB_TEMP_A, 1'b0), 0);
    queue_op(make_op(cawf_pkg::OP_DEC, 1'b1, 16'h0000, 16'h0000, cawf_pkg::PB_ZERO,   1'b0), 0);
    queue_op(make_op(cawf_pkg::OP_INC2, 1'b1, 16'hFFFF, 16'h0000, cawf_pkg::PB_TEMP_B, 1'b0), 0);
    queue_op(make_op(cawf_pkg::OP_DEC2, 1'b1, 16'h0000, 16'h0001, cawf_pkg::PB_TEMP_A, 1'b0), 0);
    queue_op(make_op(cawf_pkg::OP_NOT,  1'b0, 16'h0000, 16'h0000, cawf_pkg::PB_TEMP_A, 1'b1), 0);
    queue_op(make_op(cawf_pkg::OP_NEG,  1'b0, 16'h0000, 16'h8000, cawf_pkg::PB_TEMP_C, 1'b0), 0);
    queue_op(make_op(cawf_pkg::OP_NEG,  1'b1, 16'h0000, 16'hFF80, cawf_pkg::PB_TEMP_A, 1'b0), 0);
    queue_op(make_op(cawf_pkg::OP_NEG,  1'b0, 16'h0000, 16'h0000, cawf_pkg::PB_ZERO,   1'b1), 0);
    queue_op(make_op(cawf_pkg::OP_PASS, 1'b0, 16'hFFFF, 16'hFFFF, cawf_pkg::PB_ZERO,   1'b1), 3);
    // instruction-byte decode: group bits select cmp; inc/dec group on bit 3
    t = make_op(cawf_pkg::OP_INSTR, 1'b0, 16'h0005, 16'h0005, cawf_pkg::PB_TEMP_A, 1'b0);
    t.inc_dec_group = 1'b0;
    t.instruction_byte = 8'hFF;
    queue_op(t, 0);
    t = make_op(cawf_pkg::OP_INSTR, 1'b1, 16'h0000, 16'h0080, cawf_pkg::PB_TEMP_C, 1'b0);
    t.inc_dec_group = 1'b1;
    t.instruction_byte = 8'h08;
    queue_op(t, 0);
    t = make_op(cawf_pkg::OP_INSTR, 1'b0, 16'h0000, 16'hFFFF, cawf_pkg::PB_TEMP_A, 1'b0);
    t.inc_dec_group = 1'b1;
    t.instruction_byte = 8'hF7;
    queue_op(t, 0);

    // ---- random: back-to-back bursts or random-gap stretches, chosen per block ----
    burst = 1'b0;
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i % GAP_BLOCK == 0) burst = ($urandom_range(0, 2) == 0);
      gap = burst ? 0 : $urandom_range(0, MAX_GAP);
      queue_op(rand_op(), gap);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every transaction accepted and every result returned
    while (n_accepted < n_issued || awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (awaited_results.size() != 0) begin
      $error("%0d expected results never arrived", awaited_results.size());
      n_errors++;
    end

    $display("%0d transactions, %0d results checked, %0d mismatches",
             n_accepted, n_checked, n_errors);
    $display("opcodes hit %h, %0d constant-mode and %0d byte-width operations",
             ops_seen, n_const, n_bytew);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
